[src/sdam_pkg.sv]
// Package for the switch debouncer with action modes.
// Holds widths, register indexes and mode codes shared by the RTL and the checker.
// No dependencies.
package sdam_pkg;

    // Sizing of stored state
    localparam int MAX_POSITIONS   = 16;
    localparam int TICK_COUNT_BITS = 16;
    localparam int POS_W           = $clog2(MAX_POSITIONS);

    // Fixed register widths
    localparam int MODE_W   = 2;
    localparam int DEB_W    = 16;
    localparam int COUNT_W  = 5;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Width used to compare the stable counter with the debounce delay
    localparam int CMP_W = (TICK_COUNT_BITS > DEB_W) ? TICK_COUNT_BITS : DEB_W;
    // Width used for position limit arithmetic
    localparam int LIM_W = (COUNT_W > POS_W + 1) ? COUNT_W : POS_W + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTION_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_COUNT = 2'd3;

    // Action mode codes; the unused code behaves as momentary
    localparam logic [MODE_W-1:0] MODE_MOMENTARY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TOGGLE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CIRCULAR  = 2'd2;

    // Input commands
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_SET_POS = 1'b1;

    // Register reset values
    localparam logic [MODE_W-1:0]  RST_ACTION_MODE    = MODE_MOMENTARY;
    localparam logic               RST_ACTIVE_LEVEL   = 1'b1;
    localparam logic [DEB_W-1:0]   RST_DEBOUNCE_TICKS = 16'd50;
    localparam logic [COUNT_W-1:0] RST_POSITION_COUNT = 5'd2;

    // Event flags carried with each result
    typedef struct packed {
        logic pos;
        logic toggle;
        logic level;
    } flags_t;

endpackage

[src/switch_debounce_action_modes.sv]
// Switch debouncer with momentary, toggle and circular action modes.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one request per cycle unless stalled: either a
//   sample tick with the raw pin level (command = tick) or a set-position
//   request (command = set position, new_position). Every request gives
//   exactly one result on the output channel (out_valid / out_stall) with
//   switch_on, position and the three event flags.
//   A request accepted into the input register moves on to the result
//   register when that register is free. Throughput is one request per cycle
//   while the output does not stall; the state update for a request is one level
//   of logic between the input register and the result register.
//   When the receiver stalls, the result register holds; one more request can
//   wait in the input register, after which in_stall rises until the output
//   drains.
//   Reset clears both pipeline valids, the debounce state, the position and
//   the flags, and loads the register defaults (momentary mode, active level
//   high, 50 ticks of debounce, two positions).
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
//   edge and must only be issued while the block is idle.
// Depends on sdam_pkg.
module switch_debounce_action_modes (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic                          raw_level,
    input  logic [sdam_pkg::POS_W-1:0]    new_position,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          switch_on,
    output logic [sdam_pkg::POS_W-1:0]    position,
    output logic                          level_changed,
    output logic                          toggled,
    output logic                          position_changed,
    // configuration port
    input  logic                          cfg_we,
    input  logic [sdam_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sdam_pkg::CFG_W-1:0]    cfg_data
);
    import sdam_pkg::*;

    // Configuration registers
    logic [MODE_W-1:0]  action_mode_reg;
    logic               active_level_reg;
    logic [DEB_W-1:0]   debounce_ticks_reg;
    logic [COUNT_W-1:0] position_count_reg;

    // Input stage
    logic               in_valid_reg;
    logic               command_reg;
    logic               raw_level_reg;
    logic [POS_W-1:0]   new_position_reg;

    // Debounce and action state
    logic                       last_pressed_reg, last_pressed_next;
    logic                       accepted_reg, accepted_next;
    logic [TICK_COUNT_BITS-1:0] stable_reg, stable_next;
    logic                       on_reg, on_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    flags_t                     flags_reg, flags_next;

    // Result stage
    logic               out_valid_reg;
    logic               out_on_reg;
    logic [POS_W-1:0]   out_pos_reg;
    flags_t             out_flags_reg;

    logic               out_free;
    logic               advance;
    logic               in_accept;

    logic               pressed;
    logic               rise;
    logic               fall;
    logic               settled;
    logic [LIM_W-1:0]   pos_limit;
    logic [LIM_W-1:0]   pos_inc;

    // Handshake: the result register frees when empty or taken
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_mode_reg    <= RST_ACTION_MODE;
            active_level_reg   <= RST_ACTIVE_LEVEL;
            debounce_ticks_reg <= RST_DEBOUNCE_TICKS;
            position_count_reg <= RST_POSITION_COUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ACTION_MODE:    action_mode_reg    <= cfg_data[MODE_W-1:0];
                REG_ACTIVE_LEVEL:   active_level_reg   <= cfg_data[0];
                REG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data[DEB_W-1:0];
                REG_POSITION_COUNT: position_count_reg <= cfg_data[COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            command_reg      <= command;
            raw_level_reg    <= raw_level;
            new_position_reg <= new_position;
        end
    end

    // Position wrap point, capped at the position store size
    always_comb
    begin
        if (LIM_W'(position_count_reg) > LIM_W'(MAX_POSITIONS))
        begin
            pos_limit = LIM_W'(MAX_POSITIONS);
        end
        else
        begin
            pos_limit = LIM_W'(position_count_reg);
        end
    end

    assign pressed = (raw_level_reg == active_level_reg);
    assign pos_inc = LIM_W'(pos_reg) + LIM_W'(1);

    // Next state for the request in the input register
    always_comb
    begin
        last_pressed_next = last_pressed_reg;
        accepted_next     = accepted_reg;
        stable_next       = stable_reg;
        on_next           = on_reg;
        pos_next          = pos_reg;
        flags_next        = flags_reg;
        rise              = 1'b0;
        fall              = 1'b0;
        settled           = 1'b0;

        if (command_reg == CMD_SET_POS)
        begin
            // load the position if in range, hold the flags
            if (LIM_W'(new_position_reg) < pos_limit)
            begin
                pos_next = new_position_reg;
            end
        end
        else
        begin
            flags_next = '0;
            // restart or advance the saturating stable counter
            if (pressed != last_pressed_reg)
            begin
                stable_next = '0;
            end
            else if (stable_reg != {TICK_COUNT_BITS{1'b1}})
            begin
                stable_next = stable_reg + TICK_COUNT_BITS'(1);
            end

            settled = (CMP_W'(stable_next) >= CMP_W'(debounce_ticks_reg));
            rise    = pressed && !accepted_reg;
            fall    = !pressed && accepted_reg;

            if (settled)
            begin
                case (action_mode_reg)
                    MODE_TOGGLE:
                    begin
                        if (rise)
                        begin
                            on_next           = !on_reg;
                            flags_next.toggle = 1'b1;
                        end
                    end
                    MODE_CIRCULAR:
                    begin
                        if (rise)
                        begin
                            if (pos_inc >= pos_limit)
                            begin
                                pos_next = '0;
                            end
                            else
                            begin
                                pos_next = pos_inc[POS_W-1:0];
                            end
                            on_next        = 1'b1;
                            flags_next.pos = 1'b1;
                        end
                        if (fall)
                        begin
                            on_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        on_next          = pressed;
                        flags_next.level = (pressed != accepted_reg);
                    end
                endcase
                accepted_next = pressed;
            end
            last_pressed_next = pressed;
        end
    end

    // Commit state as the request moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pressed_reg <= 1'b0;
            accepted_reg     <= 1'b0;
            stable_reg       <= '0;
            on_reg           <= 1'b0;
            pos_reg          <= '0;
            flags_reg        <= '0;
        end
        else if (advance)
        begin
            last_pressed_reg <= last_pressed_next;
            accepted_reg     <= accepted_next;
            stable_reg       <= stable_next;
            on_reg           <= on_next;
            pos_reg          <= pos_next;
            flags_reg        <= flags_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_on_reg    <= on_next;
            out_pos_reg   <= pos_next;
            out_flags_reg <= flags_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign switch_on        = out_on_reg;
    assign position         = out_pos_reg;
    assign level_changed    = out_flags_reg.level;
    assign toggled          = out_flags_reg.toggle;
    assign position_changed = out_flags_reg.pos;

endmodule

[src/sdam_checker.sv]
// Port-level checker for the switch debouncer, bound to the top level.
// Depends on sdam_pkg and switch_debounce_action_modes.
module sdam_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          switch_on,
    input  logic [sdam_pkg::POS_W-1:0]    position,
    input  logic                          level_changed,
    input  logic                          toggled,
    input  logic                          position_changed
);
    import sdam_pkg::*;

    // Stalled result stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(position) && $stable(switch_on))
        else $error("result payload changed while stalled");

    // Backpressure on requests only comes from a stalled full output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled without output backpressure");

    // Only one mode flag can be raised by a request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({level_changed, toggled, position_changed}) <= 1)
        else $error("more than one event flag set");

    // A position step always leaves the switch held on
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && position_changed |-> switch_on)
        else $error("position advanced with switch off");

endmodule

bind switch_debounce_action_modes sdam_checker u_sdam_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .switch_on        (switch_on),
    .position         (position),
    .level_changed    (level_changed),
    .toggled          (toggled),
    .position_changed (position_changed)
);
